### sv/tcup_pkg.sv
package tcup_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int USED_W    = 32 + CNT_W;

  localparam int DVD_W     = 40;
  localparam int STEP_W    = $clog2(DVD_W);

  localparam int IN_W      = 40;
  localparam int OUT_W     = 80;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 10;

  localparam logic [CFG_AW-1:0] CFG_CLOCK_MHZ  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_TASK_COUNT = CFG_AW'(1);

  localparam logic [9:0] CLOCK_MHZ_RST = 10'd200;
  localparam logic [6:0] PCT_FULL      = 7'd100;

  typedef enum logic [2:0] {
    CMD_ENTER  = 3'd0,
    CMD_EXIT   = 3'd1,
    CMD_PEND   = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_IDLEQ  = 3'd4,
    CMD_RESET  = 3'd5
  } cmd_t;

endpackage

### sv/task_cpu_usage_profiler.sv
// Per-task run-time profiler.
// Input beats carry a command, a task number and the cycle timestamp of the
// event; every input beat yields exactly one result beat on the out_ channel.
// Enter and exit update one table entry; period end and reset walk the
// registered entries one per cycle; task and idle queries use one shared
// restoring divider that retires one quotient bit per cycle.
// Enter, exit, unknown commands and rejected tasks go straight to the result;
// period end and reset first walk the registered entries; an idle query runs
// the 40-step divider once (not at all when the period is zero), a task query
// twice, for busy_us and then cpu_pct (only the first when the period is zero).
// in_tready is high only while no item is in work, so one item is processed at
// a time; a finished result sits in the output register and the next beat is
// taken meanwhile, but a further result waits until out_tready frees that
// register.
// The cfg_ port writes clock_mhz (index 0) and task_count (index 1) at any
// cycle with cfg_we high; write it only while the block is idle.
// Synchronous reset (rst_n low) clears all counters and the task table,
// drops out_tvalid and restores clock_mhz to 200 and task_count to 0.
module task_cpu_usage_profiler
  import tcup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // command[2:0], task_id[6:3], timestamp[38:7]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // status[0], busy_us[32:1],
                                        // enters[64:33], cpu_pct[71:65],
                                        // idle_percent[78:72]
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r;

  logic [9:0]  clock_mhz_r;
  logic [4:0]  task_count_r;

  logic [31:0] start_r [MAX_TASKS];
  logic [31:0] busy_r  [MAX_TASKS];
  logic [31:0] enter_r [MAX_TASKS];
  logic [MAX_TASKS-1:0] running_r;
  logic [31:0] mark_r;
  logic [31:0] period_r;
  logic [31:0] idle_cyc_r;

  cmd_t        cmd_r;
  logic [3:0]  id_r;
  logic [31:0] stamp_r;

  logic [CNT_W-1:0]  walk_r;
  logic [USED_W-1:0] used_r;

  logic [31:0]       rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [31:0]       dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              pct_phase_r;
  logic [31:0]       opnd_r;

  logic        res_status_r;
  logic [31:0] res_run_r;
  logic [31:0] res_sw_r;
  logic [6:0]  res_cpu_r;
  logic [6:0]  res_idle_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [CNT_W-1:0]  lim;
  logic              id_ok;
  logic [TASK_W-1:0] idx;
  logic [31:0]       busy_rd;
  logic [33:0]       div_diff;
  logic              div_borrow;
  logic [31:0]       rem_nxt;
  logic [DVD_W-1:0]  quo_nxt;
  logic [6:0]        pct_nxt;
  logic [USED_W-1:0] period_ext;
  logic              out_free;

  function automatic logic [DVD_W-1:0] times100(input logic [31:0] x);
    logic [DVD_W-1:0] w;
    w = DVD_W'(x);
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

  assign lim   = (32'(task_count_r) >= 32'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                       : CNT_W'(task_count_r);
  assign id_ok = 32'(id_r) < 32'(lim);
  assign idx   = (state_r == S_WALK) ? walk_r[TASK_W-1:0] : TASK_W'(id_r);
  assign busy_rd = busy_r[idx];

  assign div_diff   = {1'b0, rem_r, quo_r[DVD_W-1]} - {2'b00, dvs_r};
  assign div_borrow = div_diff[33];
  assign rem_nxt    = div_borrow ? {rem_r[30:0], quo_r[DVD_W-1]} : div_diff[31:0];
  assign quo_nxt    = {quo_r[DVD_W-2:0], ~div_borrow};
  assign pct_nxt    = (quo_nxt > DVD_W'(100)) ? PCT_FULL : quo_nxt[6:0];

  assign period_ext = USED_W'(period_r);
  assign out_free   = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_mhz_r  <= CLOCK_MHZ_RST;
      task_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CLOCK_MHZ:  clock_mhz_r  <= cfg_wdata;
        CFG_TASK_COUNT: task_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      running_r   <= '0;
      mark_r      <= '0;
      period_r    <= '0;
      idle_cyc_r  <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        start_r[i] <= '0;
        busy_r[i]  <= '0;
        enter_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= cmd_t'(in_tdata[2:0]);
            id_r    <= in_tdata[6:3];
            stamp_r <= in_tdata[38:7];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status_r <= 1'b0;
          res_run_r    <= '0;
          res_sw_r     <= '0;
          res_cpu_r    <= '0;
          res_idle_r   <= '0;
          walk_r       <= '0;
          used_r       <= '0;
          state_r      <= S_FIN;
          case (cmd_r)
            CMD_ENTER: begin
              if (!id_ok) begin
                res_status_r <= 1'b1;
              end else begin
                start_r[idx]   <= stamp_r;
                running_r[idx] <= 1'b1;
                enter_r[idx]   <= enter_r[idx] + 32'd1;
              end
            end
            CMD_EXIT: begin
              if (!id_ok) begin
                res_status_r <= 1'b1;
              end else if (running_r[idx]) begin
                busy_r[idx]    <= busy_rd + (stamp_r - start_r[idx]);
                running_r[idx] <= 1'b0;
              end
            end
            CMD_PEND: begin
              period_r <= stamp_r - mark_r;
              mark_r   <= stamp_r;
              state_r  <= S_WALK;
            end
            CMD_QUERY: begin
              if (!id_ok) begin
                res_status_r <= 1'b1;
              end else begin
                opnd_r      <= busy_rd;
                res_sw_r    <= enter_r[idx];
                rem_r       <= '0;
                quo_r       <= DVD_W'(busy_rd);
                dvs_r       <= (clock_mhz_r == '0) ? 32'd1 : 32'(clock_mhz_r);
                step_r      <= STEP_W'(DVD_W - 1);
                pct_phase_r <= 1'b0;
                state_r     <= S_DIV;
              end
            end
            CMD_IDLEQ: begin
              if (period_r == '0) begin
                res_idle_r <= PCT_FULL;
              end else begin
                rem_r       <= '0;
                quo_r       <= times100(idle_cyc_r);
                dvs_r       <= period_r;
                step_r      <= STEP_W'(DVD_W - 1);
                pct_phase_r <= 1'b1;
                state_r     <= S_DIV;
              end
            end
            CMD_RESET: begin
              mark_r     <= stamp_r;
              period_r   <= '0;
              idle_cyc_r <= '0;
              state_r    <= S_WALK;
            end
            default: ;
          endcase
        end
        S_WALK: begin
          if (walk_r == lim) begin
            if (cmd_r == CMD_PEND) begin
              idle_cyc_r <= (period_ext > used_r) ? 32'(period_ext - used_r) : '0;
            end
            state_r <= S_FIN;
          end else begin
            used_r       <= used_r + USED_W'(busy_rd);
            busy_r[idx]  <= '0;
            enter_r[idx] <= '0;
            walk_r       <= walk_r + CNT_W'(1);
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r - STEP_W'(1);
          if (step_r == '0) begin
            if (!pct_phase_r) begin
              res_run_r <= quo_nxt[31:0];
              if (period_r == '0) begin
                state_r <= S_FIN;
              end else begin
                rem_r       <= '0;
                quo_r       <= times100(opnd_r);
                dvs_r       <= period_r;
                step_r      <= STEP_W'(DVD_W - 1);
                pct_phase_r <= 1'b1;
              end
            end else begin
              if (cmd_r == CMD_IDLEQ) begin
                res_idle_r <= pct_nxt;
              end else begin
                res_cpu_r <= pct_nxt;
              end
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= {1'b0, res_idle_r, res_cpu_r, res_sw_r, res_run_r,
                            res_status_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted beat not taken into execution");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> walk_r <= lim)
    else $error("table walk ran past registered tasks");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dvs_r != '0)
    else $error("divider started with zero divisor");

  a_status_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && res_status_r |->
      cmd_r == CMD_ENTER || cmd_r == CMD_EXIT || cmd_r == CMD_QUERY)
    else $error("rejection flagged on a command without task number");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[71:65] <= PCT_FULL && out_data_r[78:72] <= PCT_FULL)
    else $error("percentage above full scale");

  a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not moved to output register");

endmodule

### tb/usage_checker.sv
module usage_checker
  import tcup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // command[2:0], task_id[6:3], timestamp[38:7]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,  // status[0], busy_us[32:1],
                                        // enters[64:33], cpu_pct[71:65],
                                        // idle_percent[78:72]
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        status;
    logic [31:0] run_us;
    logic [31:0] switches;
    logic [6:0]  cpu;
    logic [6:0]  idle;
  } usage_t;

  logic [31:0] start_at [MAX_TASKS];
  logic [31:0] busy [MAX_TASKS];
  logic [31:0] enters [MAX_TASKS];
  logic        running_flag [MAX_TASKS];
  logic [31:0] mark;
  logic [31:0] span;
  logic [31:0] idle_cyc;
  logic [9:0]  mhz;
  logic [4:0]  ntasks;

  usage_t answers_due [$];
  usage_t want;
  usage_t got;

  function automatic int unsigned active_limit();
    return (ntasks < MAX_TASKS) ? ntasks : MAX_TASKS;
  endfunction

  function automatic logic [6:0] percent(logic [31:0] part, logic [31:0] whole);
    logic [63:0] p;
    p = ({32'b0, part} * 64'd100) / {32'b0, whole};
    return (p > 64'(PCT_FULL)) ? PCT_FULL : p[6:0];
  endfunction

  function automatic usage_t profile_step(logic [2:0] op, logic [3:0] id, logic [31:0] ts);
    usage_t      r;
    logic        known;
    logic [63:0] used;
    logic [31:0] div;
    r = '0;
    known = (id < active_limit());
    case (op)
      CMD_ENTER: begin
        if (!known) begin
          r.status = 1'b1;
        end else begin
          start_at[id] = ts;
          running_flag[id] = 1'b1;
          enters[id] = enters[id] + 32'd1;
        end
      end
      CMD_EXIT: begin
        if (!known) begin
          r.status = 1'b1;
        end else if (running_flag[id]) begin
          busy[id] = busy[id] + (ts - start_at[id]);
          running_flag[id] = 1'b0;
        end
      end
      CMD_PEND: begin
        span = ts - mark;
        mark = ts;
        used = '0;
        for (int i = 0; i < active_limit(); i++) begin
          used = used + {32'b0, busy[i]};
          busy[i] = '0;
          enters[i] = '0;
        end
        idle_cyc = ({32'b0, span} > used) ? span - used[31:0] : 32'd0;
      end
      CMD_QUERY: begin
        div = (mhz == '0) ? 32'd1 : {22'b0, mhz};
        if (!known) begin
          r.status = 1'b1;
        end else begin
          r.run_us = busy[id] / div;
          r.switches = enters[id];
          r.cpu = (span != '0) ? percent(busy[id], span) : 7'd0;
        end
      end
      CMD_IDLEQ: begin
        r.idle = (span != '0) ? percent(idle_cyc, span) : PCT_FULL;
      end
      CMD_RESET: begin
        for (int i = 0; i < active_limit(); i++) begin
          busy[i] = '0;
          enters[i] = '0;
        end
        mark = ts;
        span = '0;
        idle_cyc = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        start_at[i] = '0;
        busy[i] = '0;
        enters[i] = '0;
        running_flag[i] = 1'b0;
      end
      mark = '0;
      span = '0;
      idle_cyc = '0;
      mhz = CLOCK_MHZ_RST;
      ntasks = '0;
      answers_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[0];
        got.run_us = out_tdata[32:1];
        got.switches = out_tdata[64:33];
        got.cpu = out_tdata[71:65];
        got.idle = out_tdata[78:72];
        if (answers_due.size() == 0) begin
          errors++;
          $error("result beat with nothing outstanding: %h", out_tdata);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, got.status);
          end
          if (got.run_us !== want.run_us) begin
            errors++;
            $error("busy_us: expected %0d, got %0d", want.run_us, got.run_us);
          end
          if (got.switches !== want.switches) begin
            errors++;
            $error("enters: expected %0d, got %0d", want.switches, got.switches);
          end
          if (got.cpu !== want.cpu) begin
            errors++;
            $error("cpu_pct: expected %0d, got %0d", want.cpu, got.cpu);
          end
          if (got.idle !== want.idle) begin
            errors++;
            $error("idle_percent: expected %0d, got %0d", want.idle, got.idle);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CLOCK_MHZ:  mhz = cfg_wdata;
          CFG_TASK_COUNT: ntasks = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        answers_due.push_back(profile_step(in_tdata[2:0], in_tdata[6:3], in_tdata[38:7]));
      end
    end
    pending = answers_due.size();
  end

endmodule

### tb/testbench.sv
module testbench
  import tcup_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]        CMD_SPARE6 = 3'd6;
  localparam logic [2:0]        CMD_SPARE7 = 3'd7;
  localparam logic [CFG_AW-1:0] CFG_SPARE2 = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] CFG_SPARE3 = CFG_AW'(3);

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // command[2:0], task_id[6:3], timestamp[38:7]
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // status[0], busy_us[32:1],
                                 // enters[64:33], cpu_pct[71:65],
                                 // idle_percent[78:72]
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  int                chk_errors;
  int                chk_pending;
  logic              calm;

  always #5 clk = ~clk;

  task_cpu_usage_profiler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  usage_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .errors     (chk_errors),
    .pending    (chk_pending)
  );

  task automatic send_event(logic [2:0] op, logic [3:0] id, logic [31:0] ts);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, ts, id, op};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  initial begin
    #6_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [9:0]  mhz_v;
    logic [4:0]  tc_v;
    int          limit;
    int          sel;
    logic [2:0]  op;
    logic [3:0]  id;
    logic [31:0] now;
    logic [31:0] ts;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle share before any period, then rejects with no tasks registered
    send_event(CMD_IDLEQ, 4'd0, 32'd0);
    send_event(CMD_QUERY, 4'd0, 32'd0);
    send_event(CMD_ENTER, 4'd15, 32'hFFFF_FFFF);
    drain();
    write_reg(CFG_TASK_COUNT, 10'h3E4);
    write_reg(CFG_CLOCK_MHZ, 10'd0);
    write_reg(CFG_SPARE2, 10'h3FF);
    write_reg(CFG_SPARE3, 10'h155);

    send_event(CMD_ENTER, 4'd0, 32'd0);
    send_event(CMD_ENTER, 4'd1, 32'hFFFF_FFF0);
    send_event(CMD_EXIT, 4'd0, 32'hC000_0000);
    send_event(CMD_EXIT, 4'd1, 32'hBFFF_FFF0);
    send_event(CMD_EXIT, 4'd2, 32'd5);
    send_event(CMD_EXIT, 4'd4, 32'd5);
    send_event(CMD_QUERY, 4'd0, 32'd6);
    send_event(CMD_PEND, 4'd0, 32'd100);
    send_event(CMD_IDLEQ, 4'd0, 32'd110);
    send_event(CMD_ENTER, 4'd2, 32'd200);
    send_event(CMD_EXIT, 4'd2, 32'd1200);
    send_event(CMD_QUERY, 4'd2, 32'd1300);
    send_event(CMD_ENTER, 4'd3, 32'd1000);
    send_event(CMD_QUERY, 4'd3, 32'd1400);
    send_event(CMD_SPARE6, 4'd0, 32'hFFFF_FFFF);
    send_event(CMD_SPARE7, 4'd15, 32'd0);
    send_event(CMD_RESET, 4'd0, 32'h8000_0000);
    send_event(CMD_QUERY, 4'd2, 32'h8000_0001);
    send_event(CMD_IDLEQ, 4'd0, 32'h8000_0002);
    send_event(CMD_PEND, 4'd0, 32'h8000_0064);
    send_event(CMD_EXIT, 4'd3, 32'h8000_0070);
    send_event(CMD_IDLEQ, 4'd0, 32'h8000_0080);
    drain();

    now = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin mhz_v = 10'd1000; tc_v = 5'd16; end
        1:       begin mhz_v = 10'd1; tc_v = 5'd1; end
        2:       begin mhz_v = 10'($urandom_range(1, 1000)); tc_v = 5'd31; end
        3:       begin mhz_v = 10'h3FF; tc_v = 5'($urandom_range(0, 16)); end
        4:       begin mhz_v = 10'd0; tc_v = 5'd8; end
        default: begin
          mhz_v = 10'($urandom_range(1, 1000));
          tc_v = 5'($urandom_range(2, 16));
        end
      endcase
      write_reg(CFG_CLOCK_MHZ, mhz_v);
      write_reg(CFG_TASK_COUNT, {5'($urandom), tc_v});
      limit = (tc_v > MAX_TASKS) ? MAX_TASKS : tc_v;
      for (int k = 0; k < 170; k++) begin
        if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        now = now + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5000));
        sel = $urandom_range(0, 99);
        if (sel < 30)      op = CMD_ENTER;
        else if (sel < 55) op = CMD_EXIT;
        else if (sel < 62) op = CMD_PEND;
        else if (sel < 82) op = CMD_QUERY;
        else if (sel < 90) op = CMD_IDLEQ;
        else if (sel < 93) op = CMD_RESET;
        else if (sel < 96) op = ($urandom_range(0, 1) == 0) ? CMD_SPARE6 : CMD_SPARE7;
        else               op = 3'($urandom_range(0, 7));
        if (limit > 0 && $urandom_range(0, 99) < 85) id = 4'($urandom_range(0, limit - 1));
        else id = 4'($urandom_range(0, 15));
        ts = ($urandom_range(0, 9) == 0) ? $urandom : now;
        send_event(op, id, ts);
      end
      calm = 1'b0;
      drain();
    end

    if (chk_errors == 0 && chk_pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
